>>> sv/rdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdp_pkg
// Shared constants, control structs and the digit alphabet for the radix
// digit converter with palindrome flag.
// ----------------------------------------------------------------------------
package rdp_pkg;

  // Port field widths
  localparam int VALUE_W = 32;
  localparam int DIGIT_W = 5;
  localparam int CHAR_W  = 7;
  localparam int BASE_W  = 5;

  // Number of low input bits taken into the conversion (at most VALUE_W)
  localparam int VALUE_BITS = 32;

  // Digit store
  localparam int STORE_DEPTH = 32;
  localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
  localparam int COUNT_BITS  = $clog2(STORE_DEPTH + 1);

  // Divider: DIV_BITS dividend bits retired per cycle
  localparam int DIV_BITS   = 8;
  localparam int DIV_CYCLES = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int WORK_BITS  = DIV_CYCLES * DIV_BITS;
  localparam int STEP_BITS  = $clog2(DIV_CYCLES + 1);

  // Radix limits
  localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(20);
  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);

  // Alphabet "0123456789ABCDEFGHIJK"
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_A_SHIFT = CHAR_W'(55);
  localparam logic [CHAR_W-1:0] CHAR_LAST    = CHAR_W'(75);

  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic cmp_check;
    logic i_clear;
    logic emit_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic conv_done;
    logic cmp_done;
    logic emit_last;
    logic out_free;
  } ctrl_status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_W'(10)) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else if (d < DIGIT_W'(20)) begin
      c = CHAR_A_SHIFT + CHAR_W'(d);
    end else begin
      c = CHAR_LAST;
    end
    return c;
  endfunction

endpackage

>>> sv/rdp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdp_if
// Valid/ready channels: input values and output digits.
// ----------------------------------------------------------------------------
interface rdp_value_if;
  logic                        valid;
  logic                        ready;
  logic [rdp_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rdp_digit_if;
  logic                        valid;
  logic                        ready;
  logic [rdp_pkg::DIGIT_W-1:0] digit;
  logic [rdp_pkg::CHAR_W-1:0]  digit_char;
  logic                        last_digit;
  logic                        is_palindrome;

  modport source (output valid, output digit, output digit_char, output last_digit,
                  output is_palindrome, input ready);
  modport sink   (input valid, input digit, input digit_char, input last_digit,
                  input is_palindrome, output ready);
endinterface

>>> sv/rdp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdp_ram
// Generic RAM: one write port, two read ports with registered data.
// ----------------------------------------------------------------------------
module rdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> sv/rdp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdp_ctrl
// Sequencer: convert digit by digit, check symmetry, then emit digits.
// ----------------------------------------------------------------------------
module rdp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rdp_pkg::ctrl_status_t status,
  output rdp_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_STORE,
    S_CMP_RD,
    S_CMP_CHK,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = status.conv_done ? S_CMP_RD : S_DIV;
      end
      S_CMP_RD: begin
        if (status.cmp_done) begin
          cmd.i_clear = 1'b1;
          state_next  = S_EMIT_RD;
        end else begin
          state_next = S_CMP_CHK;
        end
      end
      S_CMP_CHK: begin
        cmd.cmp_check = 1'b1;
        state_next    = S_CMP_RD;
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          state_next    = status.emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> sv/rdp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdp_dp
// Datapath: radix register, narrow-divisor long divider, digit store,
// symmetry check and output register.
// ----------------------------------------------------------------------------
module rdp_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rdp_pkg::BASE_W-1:0]    cfg_data,
  input  logic [rdp_pkg::VALUE_W-1:0]   in_value,
  input  rdp_pkg::ctrl_cmd_t            cmd,
  output rdp_pkg::ctrl_status_t         status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rdp_pkg::DIGIT_W-1:0]   out_digit,
  output logic [rdp_pkg::CHAR_W-1:0]    out_char,
  output logic                          out_last,
  output logic                          out_pal
);

  logic [rdp_pkg::BASE_W-1:0]     base;
  logic [rdp_pkg::BASE_W-1:0]     base_eff;
  logic [rdp_pkg::WORK_BITS-1:0]  q;
  logic [rdp_pkg::WORK_BITS-1:0]  q_next;
  logic [rdp_pkg::DIGIT_W-1:0]    r;
  logic [rdp_pkg::DIGIT_W-1:0]    r_next;
  logic [rdp_pkg::STEP_BITS-1:0]  step;
  logic [rdp_pkg::COUNT_BITS-1:0] count;
  logic [rdp_pkg::COUNT_BITS-1:0] i;
  logic [rdp_pkg::COUNT_BITS-1:0] mirror;
  logic                           pal;
  logic [rdp_pkg::DIGIT_W-1:0]    rd_a;
  logic [rdp_pkg::DIGIT_W-1:0]    rd_b;

  always_comb begin
    if (base < rdp_pkg::BASE_MIN) begin
      base_eff = rdp_pkg::BASE_MIN;
    end else if (base > rdp_pkg::BASE_MAX) begin
      base_eff = rdp_pkg::BASE_MAX;
    end else begin
      base_eff = base;
    end
  end

  // DIV_BITS restoring steps per cycle; remainder stays below base
  always_comb begin
    logic [rdp_pkg::DIGIT_W:0]    rr;
    logic [rdp_pkg::DIV_BITS-1:0] top;
    logic [rdp_pkg::DIV_BITS-1:0] qb;
    rr  = {1'b0, r};
    top = q[rdp_pkg::WORK_BITS-1 -: rdp_pkg::DIV_BITS];
    qb  = '0;
    for (int k = rdp_pkg::DIV_BITS - 1; k >= 0; k--) begin
      rr = {rr[rdp_pkg::DIGIT_W-1:0], top[k]};
      if (rr >= {1'b0, base_eff}) begin
        rr    = rr - {1'b0, base_eff};
        qb[k] = 1'b1;
      end
    end
    r_next = rr[rdp_pkg::DIGIT_W-1:0];
    if (rdp_pkg::WORK_BITS > rdp_pkg::DIV_BITS) begin
      q_next = {q[rdp_pkg::WORK_BITS-rdp_pkg::DIV_BITS-1:0], qb} ;
    end else begin
      q_next = rdp_pkg::WORK_BITS'(qb);
    end
  end

  assign mirror = count - rdp_pkg::COUNT_BITS'(1) - i;

  rdp_ram #(
    .WIDTH (rdp_pkg::DIGIT_W),
    .DEPTH (rdp_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (cmd.store),
    .waddr   (count[rdp_pkg::ADDR_BITS-1:0]),
    .wdata   (r),
    .raddr_a (i[rdp_pkg::ADDR_BITS-1:0]),
    .raddr_b (mirror[rdp_pkg::ADDR_BITS-1:0]),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign status.div_last  = (step == rdp_pkg::STEP_BITS'(rdp_pkg::DIV_CYCLES - 1));
  assign status.conv_done = (q == '0) ||
                            (count == rdp_pkg::COUNT_BITS'(rdp_pkg::STORE_DEPTH - 1));
  assign status.cmp_done  = (i >= (count >> 1));
  assign status.emit_last = (i == count - rdp_pkg::COUNT_BITS'(1));
  assign status.out_free  = !out_valid || out_ready;

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q <= rdp_pkg::WORK_BITS'(in_value[rdp_pkg::VALUE_BITS-1:0]);
      r <= '0;
    end else if (cmd.div_step) begin
      q <= q_next;
      r <= r_next;
    end else if (cmd.store) begin
      r <= '0;
    end
    if (cmd.emit_load) begin
      out_digit <= rd_b;
      out_char  <= rdp_pkg::digit_char(rd_b);
      out_last  <= status.emit_last;
      out_pal   <= status.emit_last && pal;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= rdp_pkg::BASE_RESET;
      step      <= '0;
      count     <= '0;
      i         <= '0;
      pal       <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        base <= cfg_data;
      end
      if (cmd.load) begin
        step  <= '0;
        count <= '0;
        i     <= '0;
        pal   <= 1'b1;
      end else begin
        if (cmd.div_step) begin
          step <= step + rdp_pkg::STEP_BITS'(1);
        end
        if (cmd.store) begin
          step  <= '0;
          count <= count + rdp_pkg::COUNT_BITS'(1);
        end
        if (cmd.cmp_check) begin
          if (rd_a != rd_b) begin
            pal <= 1'b0;
          end
          i <= i + rdp_pkg::COUNT_BITS'(1);
        end
        if (cmd.i_clear) begin
          i <= '0;
        end
        if (cmd.emit_load) begin
          i <= i + rdp_pkg::COUNT_BITS'(1);
        end
      end
      if (cmd.emit_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= rdp_pkg::COUNT_BITS'(rdp_pkg::STORE_DEPTH))
    else $error("digit count beyond store depth");

  a_digit_below_base: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> (r < base_eff))
    else $error("stored digit not below radix");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> (!out_valid || out_ready))
    else $error("output register loaded while holding a transaction");

  a_pal_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_pal) |-> out_last)
    else $error("palindrome flag on a digit other than the last");
`endif

endmodule

>>> sv/radix_digits_palindrome_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digits_palindrome_top
// Converts an unsigned value to base 2..20 digits, emits them most
// significant first with ASCII characters and a palindrome flag.
// ----------------------------------------------------------------------------
// One value is converted at a time. Each digit comes from the long divider,
// which retires 8 dividend bits a cycle against the radix, and is then
// written to the digit store; the symmetry check then runs over the two read
// ports of the digit store, and each digit is emitted through the store's
// registered read, waiting while the output register holds an untaken digit.
// values is ready again once the last digit sits in the output register. A
// zero value gives the single digit 0 flagged as a palindrome. The radix is
// to be written through cfg_we/cfg_data only while idle, which the block
// itself does not enforce (reset 10); 0 and 1 act as 2, 21 and up act as 20.
module radix_digits_palindrome_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rdp_pkg::BASE_W-1:0] cfg_data,
  rdp_value_if.sink                  values,
  rdp_digit_if.source                digits
);

  rdp_pkg::ctrl_cmd_t    cmd;
  rdp_pkg::ctrl_status_t status;

  rdp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (values.valid),
    .in_ready (values.ready),
    .status   (status),
    .cmd      (cmd)
  );

  rdp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_value  (values.value),
    .cmd       (cmd),
    .status    (status),
    .out_valid (digits.valid),
    .out_ready (digits.ready),
    .out_digit (digits.digit),
    .out_char  (digits.digit_char),
    .out_last  (digits.last_digit),
    .out_pal   (digits.is_palindrome)
  );

endmodule
